[rtl/core/tsa_pkg.sv]
`timescale 1ns / 1ps
// Package for the thermistor sampler and averager.
// Holds the request types of the serial units and the fixed-point constants.
// Depends on nothing.
package tsa_pkg;

  localparam int MUL_W   = 64;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int NUM_W   = 24;
  localparam int STEP_W  = 7;
  localparam int REM0_W  = 7;
  localparam int SMP_W   = 10;
  localparam int PER_W   = 10;
  localparam int OFS_W   = 13;
  localparam int HUND_W  = 16;
  localparam int TENTH_W = 13;
  localparam int K_W     = 5;
  localparam int FRAC_W  = 40;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET    = 1'd1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [PER_W-1:0]  PERIOD_RESET = 10'd10;
  localparam logic [NUM_W-1:0]  RES_SCALE    = 24'd10000;
  localparam logic [STEP_W-1:0] Y_STEPS      = 7'd102;
  localparam logic [REM0_W-1:0] Y_NUMER      = 7'd100;
  localparam logic [K_W-1:0]    K_START      = 5'd23;
  localparam logic [5:0]        SQR_LAST     = 6'd39;
  localparam logic [HUND_W-1:0] HUND_BIAS    = 16'd64536;
  localparam logic [16:0]       TENTH_RECIP  = 17'd52429;

  localparam logic [MUL_W-1:0] LN2_Q63   = 64'h58B90BFBE8E7BCD6;
  localparam logic [MUL_W-1:0] K27315_Q32 = 64'd27315 << 32;

  // Floor of num * 2^bits / den for num below den, by restoring division.
  function automatic logic [MUL_W-1:0] fix_div_c(logic [MUL_W-1:0] num,
                                                 logic [MUL_W-1:0] den, int bits);
    logic [MUL_W:0]   r;
    logic [MUL_W-1:0] q;
    int               i;
    r = {1'b0, num};
    q = '0;
    for (i = 0; i < bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic [MUL_W-1:0] COEF_A = fix_div_c(64'd1143615431, 64'd1000000000000, 70);
  localparam logic [MUL_W-1:0] COEF_B = fix_div_c(64'd2310824443, 64'd10000000000000, 70);
  localparam logic [MUL_W-1:0] COEF_C =
    fix_div_c(64'd1075998838, 64'd10000000000000000, 70);

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] x;
    logic [MUL_W-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [REM0_W-1:0] rem0;
    logic [NUM_W-1:0]  num;
    logic [MUL_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

[rtl/core/tsa_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tsa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/tsa_mul.sv]
`timescale 1ns / 1ps
// Bit-serial 64 by 64 multiplier giving the full 128-bit product.
// Depends on tsa_pkg.
module tsa_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsa_pkg::mul_req_t             req,
  output logic                          done,
  output logic [tsa_pkg::PROD_W-1:0]    prod
);
  import tsa_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [MUL_W-1:0]  x_r, x_nxt;
  logic [MUL_W-1:0]  y_r, y_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [MUL_W:0]    part;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    part     = {1'b0, acc_r[PROD_W-1:MUL_W]} + (y_r[0] ? {1'b0, x_r} : '0);
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = req.x;
      y_nxt    = req.y;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = {part, acc_r[MUL_W-1:1]};
      y_nxt   = {1'b0, y_r[MUL_W-1:1]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[rtl/core/tsa_div.sv]
`timescale 1ns / 1ps
// Restoring divider that develops one quotient bit per cycle.
// Depends on tsa_pkg.
module tsa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tsa_pkg::div_req_t          req,
  output logic                       done,
  output logic [tsa_pkg::MUL_W-1:0]  quo
);
  import tsa_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [MUL_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [MUL_W-1:0]  den_r, den_nxt;
  logic [MUL_W-1:0]  quo_r, quo_nxt;
  logic [MUL_W:0]    trial;
  logic              ge;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    quo_nxt   = quo_r;
    trial     = {rem_r, num_r[NUM_W-1]};
    ge        = (trial >= {1'b0, den_r});
    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      steps_nxt = req.steps;
      rem_nxt   = MUL_W'(req.rem0);
      num_nxt   = req.num;
      den_nxt   = req.den;
      quo_nxt   = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? MUL_W'(trial - {1'b0, den_r}) : trial[MUL_W-1:0];
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      quo_nxt = {quo_r[MUL_W-2:0], ge};
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == steps_r - STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    steps_r <= steps_nxt;
    rem_r   <= rem_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    quo_r   <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/core/thermistor_sampler_averager.sv]
`timescale 1ns / 1ps
// Thermistor sampler and averager: tick counting, sample ring, mean and
// Steinhart-Hart temperature conversion. Depends on tsa_pkg, tsa_ram,
// tsa_mul and tsa_div.
//
// A tick item only advances the tick counter. An evaluate item that latches
// a new sample updates the ring and its mean in the serial divider, and
// then converts the sample by 44 passes through the bit-serial multiplier
// (40 squarings and one scaling by ln 2 for the logarithm, three for the
// polynomial) and a 102-step reciprocal division.
// An evaluate that keeps the previous sample reuses the stored conversion.
// A zero sample is never converted: it raises the fault flag, and an
// evaluate that latches one costs only the ring and mean update before
// its result. The next item is taken while a result waits.
module thermistor_sampler_averager #(
  parameter int WINDOW         = 10,
  parameter int TICKS_PER_UNIT = 100,
  parameter int ADC_FULL_SCALE = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [tsa_pkg::SMP_W-1:0]        in_adc_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tsa_pkg::HUND_W-1:0]       out_temp_hundredths,
  output logic [tsa_pkg::TENTH_W-1:0]      out_temp_tenths,
  output logic [tsa_pkg::SMP_W-1:0]        out_sample_mean,
  output logic                             out_sensor_fault,
  input  logic                             cfg_write_en,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tsa_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = $clog2(WINDOW * 1023 + 1);
  localparam int THR_W = $clog2(TICKS_PER_UNIT + 1) + PER_W;
  localparam int CMP_W = (THR_W > 16) ? THR_W : 16;
  localparam int FS_W  = $clog2(ADC_FULL_SCALE + 1);
  localparam int DEN_W = (FS_W > SMP_W + 1) ? FS_W : SMP_W + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RING  = 4'd1;
  localparam logic [3:0] S_MEAN  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_RDIV  = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_SQR   = 4'd6;
  localparam logic [3:0] S_LN    = 4'd7;
  localparam logic [3:0] S_L2    = 4'd8;
  localparam logic [3:0] S_CL2   = 4'd9;
  localparam logic [3:0] S_UL    = 4'd10;
  localparam logic [3:0] S_YDIV  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]        state_r, state_nxt;
  logic              launch_r, launch_nxt;
  logic [PER_W-1:0]  period_r, period_nxt;
  logic [OFS_W-1:0]  offset_r, offset_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WINDOW-1:0] valid_r, valid_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SMP_W-1:0]  latched_r, latched_nxt;
  logic [SMP_W-1:0]  mean_r, mean_nxt;
  logic              conv_ok_r, conv_ok_nxt;
  logic [HUND_W-1:0] conv_r, conv_nxt;
  logic [MUL_W-1:0]  m_r, m_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [5:0]        sqr_cnt_r, sqr_cnt_nxt;
  logic [MUL_W-1:0]  l_r, l_nxt;
  logic [MUL_W-1:0]  t_r, t_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [HUND_W-1:0] out_hund_r, out_hund_nxt;
  logic [TENTH_W-1:0] out_tenth_r, out_tenth_nxt;
  logic [SMP_W-1:0]  out_mean_r, out_mean_nxt;
  logic              out_fault_r, out_fault_nxt;

  mul_req_t          mul_req;
  logic              mul_done;
  logic [PROD_W-1:0] prod;
  div_req_t          div_req;
  logic              div_done;
  logic [MUL_W-1:0]  quo;

  logic              ram_we;
  logic [SMP_W-1:0]  ram_rdata;
  logic [SMP_W-1:0]  old_sample;
  logic [THR_W-1:0]  thr;
  logic [DEN_W-1:0]  res_den;
  logic [NUM_W-1:0]  res_num;
  logic [MUL_W-1:0]  sq;
  logic [NUM_W-1:0]  r_int;
  logic [MUL_W:0]    y_diff;
  logic [MUL_W-1:0]  y_mag;
  logic [HUND_W-1:0] ip;
  logic [HUND_W-1:0] hund;
  logic [32:0]       tenth_prod;
  logic              out_free;

  tsa_ram #(
    .WIDTH (SMP_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (latched_r),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  tsa_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (prod)
  );

  tsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (quo)
  );

  assign thr = THR_W'(TICKS_PER_UNIT) * THR_W'(period_r);
  assign res_den = (DEN_W'(latched_r) >= DEN_W'(ADC_FULL_SCALE)) ? DEN_W'(1)
                 : DEN_W'(ADC_FULL_SCALE) - DEN_W'(latched_r);
  assign res_num = NUM_W'(latched_r) * RES_SCALE;
  assign old_sample = valid_r[idx_r] ? ram_rdata : '0;
  assign sq = prod[125:62];
  assign r_int = (quo[NUM_W-1:0] == '0) ? NUM_W'(1) : quo[NUM_W-1:0];
  assign y_diff = {1'b0, quo} - {1'b0, K27315_Q32};
  assign y_mag = y_diff[MUL_W] ? K27315_Q32 - quo : y_diff[MUL_W-1:0];
  assign ip = y_diff[MUL_W] ? HUND_W'(16'd0 - y_mag[47:32]) : y_mag[47:32];
  assign hund = conv_r + HUND_BIAS + HUND_W'(17'(offset_r) * 17'd10);
  assign tenth_prod = 33'(hund) * 33'(TENTH_RECIP);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    mul_req.start = 1'b0;
    mul_req.x     = m_r;
    mul_req.y     = m_r;
    case (state_r)
      S_SQR: begin
        mul_req.start = launch_r;
      end
      S_LN: begin
        mul_req.start = launch_r;
        mul_req.x     = MUL_W'({k_r, frac_r});
        mul_req.y     = LN2_Q63;
      end
      S_L2: begin
        mul_req.start = launch_r;
        mul_req.x     = l_r;
        mul_req.y     = l_r;
      end
      S_CL2: begin
        mul_req.start = launch_r;
        mul_req.x     = COEF_C;
        mul_req.y     = t_r;
      end
      S_UL: begin
        mul_req.start = launch_r;
        mul_req.x     = t_r;
        mul_req.y     = l_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.rem0  = '0;
    div_req.num   = NUM_W'(sum_r);
    div_req.den   = MUL_W'(WINDOW);
    div_req.steps = STEP_W'(NUM_W);
    case (state_r)
      S_MEAN: begin
        div_req.start = launch_r;
      end
      S_RDIV: begin
        div_req.start = launch_r;
        div_req.num   = res_num;
        div_req.den   = MUL_W'(res_den);
      end
      S_YDIV: begin
        div_req.start = launch_r;
        div_req.rem0  = Y_NUMER;
        div_req.num   = '0;
        div_req.den   = t_r;
        div_req.steps = Y_STEPS;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    period_nxt    = period_r;
    offset_nxt    = offset_r;
    tick_nxt      = tick_r;
    idx_nxt       = idx_r;
    valid_nxt     = valid_r;
    sum_nxt       = sum_r;
    latched_nxt   = latched_r;
    mean_nxt      = mean_r;
    conv_ok_nxt   = conv_ok_r;
    conv_nxt      = conv_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    frac_nxt      = frac_r;
    sqr_cnt_nxt   = sqr_cnt_r;
    l_nxt         = l_r;
    t_nxt         = t_r;
    ram_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hund_nxt  = out_hund_r;
    out_tenth_nxt = out_tenth_r;
    out_mean_nxt  = out_mean_r;
    out_fault_nxt = out_fault_r;

    if (cfg_write_en) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: period_nxt = cfg_data[PER_W-1:0];
        REG_CAL_OFFSET:    offset_nxt = cfg_data[OFS_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_TICK) begin
            tick_nxt = tick_r + 16'd1;
          end else if (CMP_W'(tick_r) > CMP_W'(thr)) begin
            latched_nxt = in_adc_sample;
            tick_nxt    = '0;
            conv_ok_nxt = 1'b0;
            state_nxt   = S_RING;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_RING: begin
        ram_we            = 1'b1;
        valid_nxt[idx_r]  = 1'b1;
        sum_nxt           = sum_r - SUM_W'(old_sample) + SUM_W'(latched_r);
        idx_nxt           = (idx_r == IDX_W'(WINDOW - 1)) ? '0 : idx_r + IDX_W'(1);
        launch_nxt        = 1'b1;
        state_nxt         = S_MEAN;
      end
      S_MEAN: begin
        if (!launch_r && div_done) begin
          mean_nxt  = quo[SMP_W-1:0];
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (latched_r == '0 || conv_ok_r) begin
          state_nxt = S_OUT;
        end else begin
          launch_nxt = 1'b1;
          state_nxt  = S_RDIV;
        end
      end
      S_RDIV: begin
        if (!launch_r && div_done) begin
          m_nxt     = {1'b0, r_int, 39'd0};
          k_nxt     = K_START;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (m_r[62]) begin
          frac_nxt    = '0;
          sqr_cnt_nxt = '0;
          launch_nxt  = 1'b1;
          state_nxt   = S_SQR;
        end else begin
          m_nxt = {m_r[MUL_W-2:0], 1'b0};
          k_nxt = k_r - K_W'(1);
        end
      end
      S_SQR: begin
        if (!launch_r && mul_done) begin
          frac_nxt    = {frac_r[FRAC_W-2:0], sq[63]};
          m_nxt       = sq[63] ? {1'b0, sq[63:1]} : sq;
          sqr_cnt_nxt = sqr_cnt_r + 6'd1;
          launch_nxt  = 1'b1;
          if (sqr_cnt_r == SQR_LAST) begin
            state_nxt = S_LN;
          end
        end
      end
      S_LN: begin
        if (!launch_r && mul_done) begin
          l_nxt      = prod[126:63];
          launch_nxt = 1'b1;
          state_nxt  = S_L2;
        end
      end
      S_L2: begin
        if (!launch_r && mul_done) begin
          t_nxt      = prod[103:40];
          launch_nxt = 1'b1;
          state_nxt  = S_CL2;
        end
      end
      S_CL2: begin
        if (!launch_r && mul_done) begin
          t_nxt      = COEF_B + prod[103:40];
          launch_nxt = 1'b1;
          state_nxt  = S_UL;
        end
      end
      S_UL: begin
        if (!launch_r && mul_done) begin
          t_nxt      = COEF_A + prod[103:40];
          launch_nxt = 1'b1;
          state_nxt  = S_YDIV;
        end
      end
      S_YDIV: begin
        if (!launch_r && div_done) begin
          conv_nxt    = ip;
          conv_ok_nxt = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = mean_r;
          if (latched_r == '0) begin
            out_hund_nxt  = '0;
            out_tenth_nxt = '0;
            out_fault_nxt = 1'b1;
          end else begin
            out_hund_nxt  = hund;
            out_tenth_nxt = tenth_prod[31:19];
            out_fault_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      period_r    <= PERIOD_RESET;
      offset_r    <= '0;
      tick_r      <= '0;
      idx_r       <= '0;
      valid_r     <= '0;
      sum_r       <= '0;
      latched_r   <= '0;
      mean_r      <= '0;
      conv_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      period_r    <= period_nxt;
      offset_r    <= offset_nxt;
      tick_r      <= tick_nxt;
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      sum_r       <= sum_nxt;
      latched_r   <= latched_nxt;
      mean_r      <= mean_nxt;
      conv_ok_r   <= conv_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    conv_r      <= conv_nxt;
    m_r         <= m_nxt;
    k_r         <= k_nxt;
    frac_r      <= frac_nxt;
    sqr_cnt_r   <= sqr_cnt_nxt;
    l_r         <= l_nxt;
    t_r         <= t_nxt;
    out_hund_r  <= out_hund_nxt;
    out_tenth_r <= out_tenth_nxt;
    out_mean_r  <= out_mean_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_temp_hundredths = out_hund_r;
  assign out_temp_tenths     = out_tenth_r;
  assign out_sample_mean     = out_mean_r;
  assign out_sensor_fault    = out_fault_r;

endmodule
